// File: sv/ripv2_pkg.sv
// ============================================================================
// ripv2_pkg
// Types and constants shared by the RIPv2 packet parser modules.
// ============================================================================
package ripv2_pkg;

    // Verdict status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNCATED = 4'd1;
    localparam logic [3:0] ST_COMMAND   = 4'd2;
    localparam logic [3:0] ST_VERSION   = 4'd3;
    localparam logic [3:0] ST_ZERO      = 4'd4;
    localparam logic [3:0] ST_FAMILY    = 4'd5;
    localparam logic [3:0] ST_TAG       = 4'd6;
    localparam logic [3:0] ST_MASK      = 4'd7;
    localparam logic [3:0] ST_METRIC    = 4'd8;
    localparam logic [3:0] ST_TOO_MANY  = 4'd9;

    // RIP command codes
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_REQUEST  = 2'd1;
    localparam logic [1:0] CMD_RESPONSE = 2'd2;

    // Header and entry layout
    localparam logic [7:0]  RIP_VERSION     = 8'd2;
    localparam logic [7:0]  FAMILY_INET     = 8'd2;
    localparam logic [6:0]  UDP_HDR_BYTES   = 7'd8;
    localparam logic [6:0]  RIP_HDR_END     = 7'd12;   // UDP header plus RIP header
    localparam logic [4:0]  ENTRY_LAST_OFF  = 5'd19;
    localparam logic [4:0]  ENTRY_MASK_OFF  = 5'd11;
    localparam logic [4:0]  ENTRY_BYTES     = 5'd20;
    localparam logic [31:0] METRIC_LIMIT    = 32'd17;

    // Entry count saturation: 31 entries span 620 bytes
    localparam logic [9:0]  COUNT_SAT_BYTES = 10'd620;
    // Reciprocal of 20 in 0.16 fixed point, exact for spans up to 620
    localparam logic [20:0] COUNT_RECIP     = 21'd3277;

    // Event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } request_t;

    typedef struct packed {
        logic        is_verdict;
        logic [1:0]  rip_command;
        logic [4:0]  entry_index;
        logic [31:0] route_address;
        logic [31:0] route_mask;
        logic [31:0] next_hop;
        logic [31:0] route_metric;
        logic [3:0]  status;
        logic [4:0]  entry_count;
        logic        last_result;
    } result_t;

    // One byte's outcome: an entry, a verdict, or both
    typedef struct packed {
        logic        has_entry;
        logic        has_verdict;
        logic [1:0]  rip_command;
        logic [4:0]  entry_index;
        logic [31:0] route_address;
        logic [31:0] route_mask;
        logic [31:0] next_hop;
        logic [31:0] route_metric;
        logic [3:0]  status;
        logic [9:0]  count_span;   // entry bytes declared, clamped at 620
    } event_t;

endpackage

// File: sv/ripv2_front.sv
// ============================================================================
// ripv2_front
// Byte parser: tracks position in the packet, checks the IPv4 length fields,
// the RIP header and each route entry, and raises one event per byte that
// completes an entry or ends the packet.
// ============================================================================
module ripv2_front #(
    parameter int MAX_ENTRIES = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ripv2_pkg::request_t  request,
    input  logic                 push,
    input  logic                 full,
    output ripv2_pkg::event_t    evt,
    output logic                 evt_push
);

    // Declared entry bytes at or beyond which the count exceeds the limit
    localparam logic [15:0] TOO_MANY_BYTES = 16'(20 * (MAX_ENTRIES + 1));

    logic [15:0] pos_reg;
    logic [3:0]  hw_reg;
    logic [15:0] dl_reg;
    logic [1:0]  cmd_reg, cmd_next;
    logic [4:0]  off_reg, off_next;
    logic [4:0]  en_reg, en_next;
    logic [31:0] acc_reg [4];
    logic [31:0] acc_next [4];
    logic [3:0]  err_reg, err_next;

    logic        take;
    logic [7:0]  b;
    logic [3:0]  hw_eff;
    logic [15:0] dl_eff;
    logic [6:0]  hdr_len;
    logic [6:0]  hstart;
    logic        diff_ok;
    logic [15:0] diff;
    logic [15:0] entry_end;
    logic        entries_left;
    logic [9:0]  span;
    logic [3:0]  err_a;
    logic [3:0]  code;
    logic        in_entry;
    logic        emit;
    logic [3:0]  off_m4;
    logic [1:0]  acc_k;
    logic [1:0]  acc_sh;
    logic [31:0] mask_be;
    logic [31:0] mask_inv;
    logic [31:0] metric_be;
    logic [16:0] received;
    logic [15:0] need;
    logic        trunc;

    assign take = push && !full;
    assign b    = request.data_byte;

    // Resolve header length and total length as updated by this byte
    always_comb
    begin
        hw_eff = (pos_reg == 16'd0) ? b[3:0] : hw_reg;
        dl_eff = dl_reg;
        if (pos_reg == 16'd2)
        begin
            dl_eff = {b, dl_reg[7:0]};
        end
        else if (pos_reg == 16'd3)
        begin
            dl_eff = {dl_reg[15:8], b};
        end
    end

    assign hdr_len      = {1'b0, hw_eff, 2'b00} + ripv2_pkg::RIP_HDR_END;
    assign hstart       = {1'b0, hw_eff, 2'b00} + ripv2_pkg::UDP_HDR_BYTES;
    assign diff_ok      = dl_eff >= {9'd0, hdr_len};
    assign diff         = dl_eff - {9'd0, hdr_len};
    assign entry_end    = {7'd0, en_reg, 4'd0} + {9'd0, en_reg, 2'd0}
                        + {11'd0, ripv2_pkg::ENTRY_BYTES};
    assign entries_left = diff_ok && (diff >= entry_end);

    // Clamp declared entry bytes for the verdict count
    always_comb
    begin
        if (!diff_ok)
        begin
            span = 10'd0;
        end
        else if (diff >= {6'd0, ripv2_pkg::COUNT_SAT_BYTES})
        begin
            span = ripv2_pkg::COUNT_SAT_BYTES;
        end
        else
        begin
            span = diff[9:0];
        end
    end

    // Flag too many entries once the length is complete
    assign err_a = (pos_reg == 16'd3 && diff_ok && diff >= TOO_MANY_BYTES
                    && err_reg == ripv2_pkg::ST_OK) ? ripv2_pkg::ST_TOO_MANY : err_reg;

    assign off_m4 = 4'(off_reg - 5'd4);
    assign acc_k  = off_m4[3:2];
    assign acc_sh = off_m4[1:0];

    // Check RIP header and entry bytes
    always_comb
    begin
        cmd_next  = cmd_reg;
        off_next  = off_reg;
        en_next   = en_reg;
        code      = ripv2_pkg::ST_OK;
        in_entry  = 1'b0;
        emit      = 1'b0;
        mask_be   = '0;
        mask_inv  = '0;
        metric_be = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc_next[i] = acc_reg[i];
        end

        priority if (pos_reg == {9'd0, hstart})
        begin
            if (b == {6'd0, ripv2_pkg::CMD_REQUEST} || b == {6'd0, ripv2_pkg::CMD_RESPONSE})
            begin
                cmd_next = b[1:0];
            end
            else
            begin
                cmd_next = ripv2_pkg::CMD_NONE;
                code     = ripv2_pkg::ST_COMMAND;
            end
        end
        else if (pos_reg == {9'd0, hstart} + 16'd1)
        begin
            if (b != ripv2_pkg::RIP_VERSION)
            begin
                code = ripv2_pkg::ST_VERSION;
            end
        end
        else if (pos_reg == {9'd0, hstart} + 16'd2 || pos_reg == {9'd0, hstart} + 16'd3)
        begin
            if (b != 8'd0)
            begin
                code = ripv2_pkg::ST_ZERO;
            end
        end
        else if (pos_reg >= {9'd0, hstart} + 16'd4 && err_a == ripv2_pkg::ST_OK
                 && entries_left)
        begin
            in_entry = 1'b1;
            priority if (off_reg == 5'd0)
            begin
                if (b != 8'd0)
                begin
                    code = ripv2_pkg::ST_FAMILY;
                end
            end
            else if (off_reg == 5'd1)
            begin
                if (b != ((cmd_reg == ripv2_pkg::CMD_REQUEST) ? 8'd0 : ripv2_pkg::FAMILY_INET))
                begin
                    code = ripv2_pkg::ST_FAMILY;
                end
            end
            else if (off_reg == 5'd2 || off_reg == 5'd3)
            begin
                if (b != 8'd0)
                begin
                    code = ripv2_pkg::ST_TAG;
                end
            end
            else
            begin
                if (acc_sh == 2'd0)
                begin
                    acc_next[acc_k] = {24'd0, b};
                end
                else
                begin
                    acc_next[acc_k][{acc_sh, 3'b000} +: 8] = b;
                end
                // Netmask must be ones then zeros, read big endian
                if (off_reg == ripv2_pkg::ENTRY_MASK_OFF)
                begin
                    mask_be  = {acc_next[1][7:0], acc_next[1][15:8],
                                acc_next[1][23:16], acc_next[1][31:24]};
                    mask_inv = ~mask_be;
                    if ((mask_inv & (mask_inv + 32'd1)) != 32'd0)
                    begin
                        code = ripv2_pkg::ST_MASK;
                    end
                end
                // Metric closes the entry
                if (off_reg == ripv2_pkg::ENTRY_LAST_OFF)
                begin
                    metric_be = {acc_next[3][7:0], acc_next[3][15:8],
                                 acc_next[3][23:16], acc_next[3][31:24]};
                    if (metric_be < 32'd1 || metric_be >= ripv2_pkg::METRIC_LIMIT)
                    begin
                        code = ripv2_pkg::ST_METRIC;
                    end
                end
            end

            // Advance within the entry while it stays clean
            if (code == ripv2_pkg::ST_OK)
            begin
                if (off_reg == ripv2_pkg::ENTRY_LAST_OFF)
                begin
                    emit     = 1'b1;
                    en_next  = en_reg + 5'd1;
                    off_next = 5'd0;
                end
                else
                begin
                    off_next = off_reg + 5'd1;
                end
            end
        end
        else
        begin
            code = ripv2_pkg::ST_OK;
        end
    end

    // Keep the first error, then check for truncation on the final byte
    always_comb
    begin
        err_next = err_a;
        if (err_a == ripv2_pkg::ST_OK && code != ripv2_pkg::ST_OK)
        begin
            err_next = code;
        end
    end

    assign received = {1'b0, pos_reg} + 17'd1;
    assign need     = (dl_eff > ({9'd0, hstart} + 16'd4)) ? dl_eff : ({9'd0, hstart} + 16'd4);
    assign trunc    = received < {1'b0, need};

    // Build the event for this byte
    always_comb
    begin
        evt.has_entry     = emit;
        evt.has_verdict   = request.final_byte;
        evt.rip_command   = cmd_next;
        evt.entry_index   = en_reg;
        evt.route_address = acc_next[0];
        evt.route_mask    = acc_next[1];
        evt.next_hop      = acc_next[2];
        evt.route_metric  = acc_next[3];
        evt.status        = (err_next == ripv2_pkg::ST_OK && trunc)
                          ? ripv2_pkg::ST_TRUNCATED : err_next;
        evt.count_span    = span;
    end

    assign evt_push = take && (emit || request.final_byte);

    // Hold field accumulators
    always_ff @(posedge clk)
    begin
        if (take && in_entry)
        begin
            for (int i = 0; i < 4; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    // Advance parser state, drop back to start after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hw_reg  <= '0;
            dl_reg  <= '0;
            cmd_reg <= ripv2_pkg::CMD_NONE;
            off_reg <= '0;
            en_reg  <= '0;
            err_reg <= ripv2_pkg::ST_OK;
        end
        else if (take)
        begin
            if (request.final_byte)
            begin
                pos_reg <= '0;
                hw_reg  <= '0;
                dl_reg  <= '0;
                cmd_reg <= ripv2_pkg::CMD_NONE;
                off_reg <= '0;
                en_reg  <= '0;
                err_reg <= ripv2_pkg::ST_OK;
            end
            else
            begin
                pos_reg <= (pos_reg == 16'hffff) ? pos_reg : pos_reg + 16'd1;
                hw_reg  <= hw_eff;
                dl_reg  <= dl_eff;
                cmd_reg <= cmd_next;
                off_reg <= off_next;
                en_reg  <= en_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

// File: sv/ripv2_queue.sv
// ============================================================================
// ripv2_queue
// Short event queue that lets the parser and the result side stall apart.
// ============================================================================
module ripv2_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  ripv2_pkg::event_t  wr_evt,
    input  logic               rd_en,
    output ripv2_pkg::event_t  head,
    output logic               full,
    output logic               empty
);

    ripv2_pkg::event_t slot_reg [ripv2_pkg::QUEUE_DEPTH];

    logic [ripv2_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [ripv2_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [ripv2_pkg::QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (ripv2_pkg::QUEUE_AW + 1)'(ripv2_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Store incoming events
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_evt;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/ripv2_back.sv
// ============================================================================
// ripv2_back
// Result side: turns each queued event into an entry result, a verdict, or
// an entry followed by a verdict, and works out the declared entry count.
// ============================================================================
module ripv2_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ripv2_pkg::event_t  head,
    input  logic               head_valid,
    input  logic               pop,
    output ripv2_pkg::result_t result,
    output logic               head_done
);

    logic        entry_done_reg;
    logic        show_entry;
    logic        taken;
    logic [20:0] count_prod;

    assign show_entry = head.has_entry && !entry_done_reg;
    assign taken      = pop && head_valid;
    assign head_done  = taken && !(show_entry && head.has_verdict);

    // Divide the declared entry bytes by the entry size
    assign count_prod = {11'd0, head.count_span} * ripv2_pkg::COUNT_RECIP;

    // Present the entry first, then the verdict
    always_comb
    begin
        result.is_verdict    = !show_entry;
        result.rip_command   = head.rip_command;
        result.entry_index   = show_entry ? head.entry_index : 5'd0;
        result.route_address = show_entry ? head.route_address : 32'd0;
        result.route_mask    = show_entry ? head.route_mask : 32'd0;
        result.next_hop      = show_entry ? head.next_hop : 32'd0;
        result.route_metric  = show_entry ? head.route_metric : 32'd0;
        result.status        = show_entry ? ripv2_pkg::ST_OK : head.status;
        result.entry_count   = show_entry ? 5'd0 : count_prod[20:16];
        result.last_result   = show_entry ? !head.has_verdict : 1'b1;
    end

    // Mark the entry half of a combined event as delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_done_reg <= 1'b0;
        end
        else if (taken)
        begin
            entry_done_reg <= show_entry && head.has_verdict;
        end
    end

endmodule

// File: sv/ripv2_packet_parser.sv
// ============================================================================
// ripv2_packet_parser
// RIPv2 packet parser: checks an IPv4/UDP/RIPv2 packet byte by byte, emits
// each good route entry and ends each packet with a verdict.
// ============================================================================
//
//  Channel  | Handshake          | Payload                        | Per request
//  ---------+--------------------+--------------------------------+----------------------
//  input    | push / full        | request  (data_byte, final)    | one packet byte
//  results  | pop  / empty       | result   (entry or verdict)    | zero, one or two
//
//  One byte is taken every cycle while full is low; the parser checks it combinationally.
//  A result is visible once its event, registered in the queue, reaches the queue head.
//  A byte that ends an entry and the packet gives two results, popped one
//  after the other from one event queue slot.
//  full rises only when the four-slot event queue is full.
//  Reset clears parser state and the queue; no clearing pass.
//
module ripv2_packet_parser #(
    parameter int MAX_ENTRIES = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ripv2_pkg::request_t  request,
    input  logic                 pop,
    output logic                 empty,
    output ripv2_pkg::result_t   result
);

    ripv2_pkg::event_t evt;
    ripv2_pkg::event_t head;
    logic              evt_push;
    logic              head_done;

    // Parse bytes into events
    ripv2_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .push     (push),
        .full     (full),
        .evt      (evt),
        .evt_push (evt_push)
    );

    // Buffer events between the two sides
    ripv2_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (evt_push),
        .wr_evt (evt),
        .rd_en  (head_done),
        .head   (head),
        .full   (full),
        .empty  (empty)
    );

    // Expand events into results
    ripv2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .result     (result),
        .head_done  (head_done)
    );

endmodule
